/* rtl/core/iss_pkg.sv */
package iss_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  localparam int unsigned OpW      = 3;
  localparam int unsigned PosW     = 9;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CountW   = 9;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;

  localparam int unsigned InBits   = OpW + PosW + WordW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits  = WordW + 1 + CountW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_TAIL  = 3'd0,
    OP_POP_TAIL   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_SIZE       = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

endpackage

/* rtl/core/indexed_sequence_store_top.sv */
// Ordered store of up to iss_pkg::Capacity signed 32-bit words.
// Each transfer on the s_axis channel carries one operation (push or pop at
// either end, insert or erase at a one-based position, clear, size query).
// Each operation yields exactly one transfer on the m_axis channel with the
// popped word, a success flag and the count after the operation.
// The words sit in a memory with one read and one write port, used as a
// circular buffer, so the memory sets the rate: pushes, an insert at the end,
// clear, size and failed operations finish when accepted, pops pass through
// the read state, and an insert or erase that moves words one place passes
// through the shift state, one word per cycle through a read/write-back
// pipeline; an erase of the last word passes through it with no word moved.
// The result lands in an output register; a new operation is accepted while
// that result is still waiting. If the receiver stalls and a second result
// is ready, the block holds it and takes no new operation until the output
// register frees up.
// Reset empties the store at once; memory contents are not cleared and are
// never read before they are written.
module indexed_sequence_store_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // opcode [2:0], position [11:3], value_in [43:12], zero padding above
  input  logic [iss_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // value_out [31:0], ok [32], count [41:33], zero padding above
  output logic [iss_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned AddrW = iss_pkg::AddrW;
  localparam int unsigned CntW  = iss_pkg::CntW;
  localparam int unsigned WordW = iss_pkg::WordW;
  localparam int unsigned CmpW  = iss_pkg::CmpW;

  function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] base,
                                            input logic [CntW-1:0]  off);
    logic [CntW:0] sum;
    sum = (CntW+1)'(base) + (CntW+1)'(off);
    if (sum >= (CntW+1)'(iss_pkg::Capacity)) begin
      sum = sum - (CntW+1)'(iss_pkg::Capacity);
    end
    return sum[AddrW-1:0];
  endfunction

  logic [WordW-1:0] mem_q [iss_pkg::Capacity];
  logic [WordW-1:0] mem_rd_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [WordW-1:0] mem_wd;

  iss_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  j_q, j_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic             wpend_q, wpend_d;
  logic [AddrW-1:0] wa_q, wa_d;
  logic             ins_q, ins_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [WordW-1:0] word_q, word_d;
  logic [WordW-1:0] rv_q, rv_d;
  logic             rok_q, rok_d;
  logic             out_valid_q, out_valid_d;
  logic [iss_pkg::OutDataW-1:0] out_data_q, out_data_d;

  iss_pkg::op_e                in_op;
  logic [iss_pkg::PosW-1:0]    in_pos;
  logic [WordW-1:0]            in_word;
  logic [CmpW-1:0]             in_idx, cnt_w;
  logic                        in_acc, full, out_free;
  logic                        fin, fin_ok;
  logic [WordW-1:0]            fin_val;
  logic [AddrW-1:0]            head_dec;

  assign in_op   = iss_pkg::op_e'(s_axis_tdata[iss_pkg::OpW-1:0]);
  assign in_pos  = s_axis_tdata[iss_pkg::OpW +: iss_pkg::PosW];
  assign in_word = s_axis_tdata[iss_pkg::OpW + iss_pkg::PosW +: WordW];
  assign in_idx  = (in_pos == '0) ? '0 : CmpW'(in_pos - 1'b1);
  assign cnt_w   = CmpW'(cnt_q);

  assign s_axis_tready = (state_q == iss_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CntW'(iss_pkg::Capacity));
  assign out_free      = !out_valid_q || m_axis_tready;
  assign head_dec      = (head_q == '0) ? AddrW'(iss_pkg::Capacity - 1) : head_q - 1'b1;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    head_d   = head_q;
    j_d      = j_q;
    rem_d    = rem_q;
    wpend_d  = 1'b0;
    wa_d     = wa_q;
    ins_d    = ins_q;
    idx_d    = idx_q;
    word_d   = word_q;
    rv_d     = rv_q;
    rok_d    = rok_q;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = word_q;
    mem_re   = 1'b0;
    mem_ra   = '0;
    fin      = 1'b0;
    fin_ok   = 1'b0;
    fin_val  = '0;

    unique case (state_q)
      iss_pkg::S_IDLE: begin
        if (in_acc) begin
          word_d = in_word;
          idx_d  = CntW'(in_idx);
          ins_d  = (in_op == iss_pkg::OP_INSERT);
          unique case (in_op)
            iss_pkg::OP_PUSH_TAIL: begin
              fin = 1'b1;
              if (!full) begin
                mem_we = 1'b1;
                mem_wa = phys(head_q, cnt_q);
                mem_wd = in_word;
                cnt_d  = cnt_q + 1'b1;
                fin_ok = 1'b1;
              end
            end
            iss_pkg::OP_PUSH_FRONT: begin
              fin = 1'b1;
              if (!full) begin
                mem_we = 1'b1;
                mem_wa = head_dec;
                mem_wd = in_word;
                head_d = head_dec;
                cnt_d  = cnt_q + 1'b1;
                fin_ok = 1'b1;
              end
            end
            iss_pkg::OP_POP_TAIL: begin
              if (cnt_q != '0) begin
                mem_re  = 1'b1;
                mem_ra  = phys(head_q, cnt_q - 1'b1);
                cnt_d   = cnt_q - 1'b1;
                state_d = iss_pkg::S_READ;
              end else begin
                fin = 1'b1;
              end
            end
            iss_pkg::OP_POP_FRONT: begin
              if (cnt_q != '0) begin
                mem_re  = 1'b1;
                mem_ra  = head_q;
                head_d  = phys(head_q, CntW'(1));
                cnt_d   = cnt_q - 1'b1;
                state_d = iss_pkg::S_READ;
              end else begin
                fin = 1'b1;
              end
            end
            iss_pkg::OP_INSERT: begin
              if (!full && in_idx <= cnt_w) begin
                if (in_idx == cnt_w) begin
                  fin    = 1'b1;
                  mem_we = 1'b1;
                  mem_wa = phys(head_q, cnt_q);
                  mem_wd = in_word;
                  cnt_d  = cnt_q + 1'b1;
                  fin_ok = 1'b1;
                end else begin
                  j_d     = cnt_q - 1'b1;
                  rem_d   = cnt_q - CntW'(in_idx);
                  state_d = iss_pkg::S_SHIFT;
                end
              end else begin
                fin = 1'b1;
              end
            end
            iss_pkg::OP_ERASE: begin
              if (in_idx < cnt_w) begin
                j_d     = CntW'(in_idx) + 1'b1;
                rem_d   = cnt_q - CntW'(in_idx) - 1'b1;
                state_d = iss_pkg::S_SHIFT;
              end else begin
                fin = 1'b1;
              end
            end
            iss_pkg::OP_CLEAR: begin
              fin    = 1'b1;
              fin_ok = 1'b1;
              cnt_d  = '0;
            end
            iss_pkg::OP_SIZE: begin
              fin    = 1'b1;
              fin_ok = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      iss_pkg::S_READ: begin
        fin     = 1'b1;
        fin_ok  = 1'b1;
        fin_val = mem_rd_q;
      end
      iss_pkg::S_SHIFT: begin
        if (wpend_q) begin
          mem_we = 1'b1;
          mem_wa = wa_q;
          mem_wd = mem_rd_q;
        end
        if (rem_q != '0) begin
          mem_re  = 1'b1;
          mem_ra  = phys(head_q, j_q);
          wpend_d = 1'b1;
          wa_d    = ins_q ? phys(head_q, j_q + 1'b1) : phys(head_q, j_q - 1'b1);
          j_d     = ins_q ? j_q - 1'b1 : j_q + 1'b1;
          rem_d   = rem_q - 1'b1;
        end else if (!wpend_q) begin
          fin    = 1'b1;
          fin_ok = 1'b1;
          if (ins_q) begin
            mem_we = 1'b1;
            mem_wa = phys(head_q, idx_q);
            mem_wd = word_q;
            cnt_d  = cnt_q + 1'b1;
          end else begin
            cnt_d  = cnt_q - 1'b1;
          end
        end
      end
      iss_pkg::S_RESP: begin
        fin     = 1'b1;
        fin_ok  = rok_q;
        fin_val = rv_q;
      end
      default: begin
        state_d = iss_pkg::S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_data_d  = iss_pkg::OutDataW'({iss_pkg::CountW'(cnt_d), fin_ok, fin_val});
        state_d     = iss_pkg::S_IDLE;
      end else begin
        rv_d    = fin_val;
        rok_d   = fin_ok;
        state_d = iss_pkg::S_RESP;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iss_pkg::S_IDLE;
      cnt_q       <= '0;
      head_q      <= '0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      wpend_q     <= wpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q        <= j_d;
    rem_q      <= rem_d;
    wa_q       <= wa_d;
    ins_q      <= ins_d;
    idx_q      <= idx_d;
    word_q     <= word_d;
    rv_q       <= rv_d;
    rok_q      <= rok_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(iss_pkg::Capacity))
    else $error("store count exceeds capacity");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != iss_pkg::S_IDLE || out_valid_q))
    else $error("accepted operation produced neither work nor a result");

  a_wpend_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpend_q |-> state_q == iss_pkg::S_SHIFT)
    else $error("pending write-back outside the shift sequence");

  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == iss_pkg::S_READ |=> (state_q == iss_pkg::S_IDLE || state_q == iss_pkg::S_RESP))
    else $error("pop did not complete after its read cycle");

  a_shift_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == iss_pkg::S_SHIFT |-> rem_q <= cnt_q)
    else $error("shift length exceeds stored count");

endmodule
